// ----- design/gah_pkg.sv -----
// ----------------------------------------------------------------------------
// gah_pkg: shared types and codes of the generational handle allocator
// Request codes, result status codes, the front-to-back request record and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package gah_pkg;

  localparam int unsigned GenW = 32;
  localparam int unsigned TagW = 32;
  localparam logic [GenW-1:0] GenMax = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FIND    = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_RELEASE,
    KIND_FIND,
    KIND_BAD
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_INVALID   = 2'd2,
    STATUS_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic {
    BK_WAIT,
    BK_EXEC
  } state_e;

  // Request record as it leaves the front queue (the index travels apart,
  // since its width follows the slot count).
  typedef struct packed {
    kind_e           kind;
    logic [GenW-1:0] gen;
    logic [TagW-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [GenW-1:0] gen;
    logic [TagW-1:0] owner;
  } slot_t;

endpackage

// ----- design/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator: generational slot map
// Allocates, releases and looks up generation-checked handles over a table
// of SLOT_COUNT slots with a LIFO free stack.
// ----------------------------------------------------------------------------
// Each request passes the queue, then a read of the slot table and free stack,
// a check-and-write, and the result register; done_o rises with the result.
// The back end takes a new request only once the last one is through, as it
// reads then writes the single-ported slot table and free stack; two requests can wait in the queue.
// Reset clears the counters and control only; the tables are not swept.
// The receiver cannot stall: each result is shown for exactly one cycle.
module generational_handle_allocator import gah_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] handle_index_i,
  input  logic [GenW-1:0]               handle_generation_i,
  input  logic [TagW-1:0]               owner_tag_i,
  output logic                          done_o,
  output logic [$clog2(SLOT_COUNT)-1:0] slot_index_o,
  output logic [GenW-1:0]               slot_generation_o,
  output logic [TagW-1:0]               found_owner_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  logic            q_valid, q_pop;
  req_t            q_req;
  logic [IdxW-1:0] q_idx;

  gah_front #(
    .IdxW (IdxW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .op_i    (operation_i),
    .idx_i   (handle_index_i),
    .gen_i   (handle_generation_i),
    .tag_i   (owner_tag_i),
    .full_o  (busy),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .req_o   (q_req),
    .idx_o   (q_idx)
  );

  gah_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_valid),
    .pop_o             (q_pop),
    .req_i             (q_req),
    .idx_i             (q_idx),
    .done_o            (done_o),
    .slot_index_o      (slot_index_o),
    .slot_generation_o (slot_generation_o),
    .found_owner_o     (found_owner_o),
    .status_o          (status_o)
  );

endmodule

// ----- design/gah_front.sv -----
// ----------------------------------------------------------------------------
// gah_front: request intake
// Decodes the operation code of each request and holds up to two decoded
// requests in a small queue until the back end takes them.
// ----------------------------------------------------------------------------
module gah_front import gah_pkg::*; #(
  parameter int unsigned IdxW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [1:0]      op_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [GenW-1:0] gen_i,
  input  logic [TagW-1:0] tag_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output req_t            req_o,
  output logic [IdxW-1:0] idx_o
);

  req_t            req_mem [2];
  logic [IdxW-1:0] idx_mem [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  req_t            req_in;
  logic            do_push, do_pop;

  always_comb begin
    req_in.gen = gen_i;
    req_in.tag = tag_i;
    unique case (op_e'(op_i))
      OP_ALLOC:   req_in.kind = KIND_ALLOC;
      OP_RELEASE: req_in.kind = KIND_RELEASE;
      OP_FIND:    req_in.kind = KIND_FIND;
      default:    req_in.kind = KIND_BAD;
    endcase
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      req_mem[wr_ptr_q] <= req_in;
      idx_mem[wr_ptr_q] <= idx_i;
    end
  end

  assign req_o = req_mem[rd_ptr_q];
  assign idx_o = idx_mem[rd_ptr_q];

endmodule

// ----- design/gah_back.sv -----
// ----------------------------------------------------------------------------
// gah_back: slot table execution
// Reads the slot table and the free stack for one request, then checks the
// handle, updates the tables and registers the result.
// ----------------------------------------------------------------------------
module gah_back import gah_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned IdxW       = 10,
  parameter int unsigned CntW       = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            pop_o,
  input  req_t            req_i,
  input  logic [IdxW-1:0] idx_i,
  output logic            done_o,
  output logic [IdxW-1:0] slot_index_o,
  output logic [GenW-1:0] slot_generation_o,
  output logic [TagW-1:0] found_owner_o,
  output logic [1:0]      status_o
);

  localparam logic [CntW-1:0] SlotMax = CntW'(SLOT_COUNT);

  // Each free stack entry also keeps the generation the slot will hand out,
  // so a reuse needs no second read of the slot table.
  slot_t           slot_mem      [SLOT_COUNT];
  logic [IdxW-1:0] stack_idx_mem [SLOT_COUNT];
  logic [GenW-1:0] stack_gen_mem [SLOT_COUNT];

  state_e          state_q, state_d;
  req_t            req_q;
  logic [IdxW-1:0] idx_q;
  slot_t           slot_rd_q;
  logic [IdxW-1:0] stk_idx_rd_q;
  logic [GenW-1:0] stk_gen_rd_q;
  logic [CntW-1:0] free_count_q, free_count_d;
  logic [CntW-1:0] high_water_q, high_water_d;
  logic [CntW-1:0] stk_top;

  logic            done_q;
  logic [IdxW-1:0] res_idx_q, res_idx_d;
  logic [GenW-1:0] res_gen_q, res_gen_d;
  logic [TagW-1:0] res_owner_q, res_owner_d;
  status_e         res_status_q, res_status_d;

  logic            exec;
  logic            slot_we, stack_we;
  logic [IdxW-1:0] slot_waddr;
  slot_t           slot_wdata;
  logic            current;

  // Sequencer: the read is taken on leaving BK_WAIT, then BK_EXEC checks and writes.
  always_comb begin
    unique case (state_q)
      BK_WAIT: state_d = valid_i ? BK_EXEC : BK_WAIT;
      BK_EXEC: state_d = BK_WAIT;
      default: state_d = BK_WAIT;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    exec  = 1'b0;
    unique case (state_q)
      BK_WAIT: pop_o = valid_i;
      BK_EXEC: exec  = 1'b1;
      default: ;
    endcase
  end

  assign stk_top = free_count_q - CntW'(1);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_q        <= req_i;
      idx_q        <= idx_i;
      slot_rd_q    <= slot_mem[idx_i];
      stk_idx_rd_q <= stack_idx_mem[stk_top[IdxW-1:0]];
      stk_gen_rd_q <= stack_gen_mem[stk_top[IdxW-1:0]];
    end
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (stack_we) begin
      stack_idx_mem[free_count_q[IdxW-1:0]] <= idx_q;
      stack_gen_mem[free_count_q[IdxW-1:0]] <= slot_rd_q.gen + GenW'(1);
    end
  end

  assign current = ({{(CntW-IdxW){1'b0}}, idx_q} < high_water_q)
                   && (slot_rd_q.gen == req_q.gen);

  always_comb begin
    free_count_d = free_count_q;
    high_water_d = high_water_q;
    slot_we      = 1'b0;
    stack_we     = 1'b0;
    slot_waddr   = idx_q;
    slot_wdata   = '{gen: slot_rd_q.gen + GenW'(1), owner: '0};
    res_idx_d    = '0;
    res_gen_d    = '0;
    res_owner_d  = '0;
    res_status_d = STATUS_OK;
    if (exec) begin
      unique case (req_q.kind)
        KIND_ALLOC: begin
          if (free_count_q != '0) begin
            free_count_d = stk_top;
            slot_we      = 1'b1;
            slot_waddr   = stk_idx_rd_q;
            slot_wdata   = '{gen: stk_gen_rd_q, owner: req_q.tag};
            res_idx_d    = stk_idx_rd_q;
            res_gen_d    = stk_gen_rd_q;
          end else if (high_water_q < SlotMax) begin
            // A fresh slot starts at generation zero.
            high_water_d = high_water_q + CntW'(1);
            slot_we      = 1'b1;
            slot_waddr   = high_water_q[IdxW-1:0];
            slot_wdata   = '{gen: '0, owner: req_q.tag};
            res_idx_d    = high_water_q[IdxW-1:0];
          end else begin
            res_status_d = STATUS_FULL;
          end
        end
        KIND_RELEASE: begin
          priority if (!current || slot_rd_q.owner == '0) begin
            res_status_d = STATUS_INVALID;
          end else if (slot_rd_q.gen == GenMax) begin
            res_status_d = STATUS_EXHAUSTED;
          end else if (free_count_q < SlotMax) begin
            slot_we      = 1'b1;
            stack_we     = 1'b1;
            free_count_d = free_count_q + CntW'(1);
          end else begin
            res_status_d = STATUS_INVALID;
          end
        end
        KIND_FIND: begin
          if (current) begin
            res_owner_d = slot_rd_q.owner;
          end else begin
            res_status_d = STATUS_INVALID;
          end
        end
        default: res_status_d = STATUS_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_WAIT;
      free_count_q <= '0;
      high_water_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      high_water_q <= high_water_d;
      done_q       <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_idx_q    <= res_idx_d;
      res_gen_q    <= res_gen_d;
      res_owner_q  <= res_owner_d;
      res_status_q <= res_status_d;
    end
  end

  assign done_o            = done_q;
  assign slot_index_o      = res_idx_q;
  assign slot_generation_o = res_gen_q;
  assign found_owner_o     = res_owner_q;
  assign status_o          = res_status_q;

endmodule

// ----- design/gah_checker.sv -----
// ----------------------------------------------------------------------------
// gah_checker: port-level checks of the handle allocator
// Watches result spacing, the consistency of result fields and the idle state after reset.
// ----------------------------------------------------------------------------
module gah_checker import gah_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [$clog2(SLOT_COUNT)-1:0] slot_index_o,
  input logic [GenW-1:0]               slot_generation_o,
  input logic [TagW-1:0]               found_owner_o,
  input logic [1:0]                    status_o
);

  // The back end returns to BK_WAIT after each request, so results never abut.
  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results in consecutive cycles");

  // A failed request returns nothing but its status.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |->
      (slot_index_o == '0 && slot_generation_o == '0 && found_owner_o == '0))
    else $error("failed request carries data");

  // An owner only comes back from a successful find, which carries no slot.
  a_owner_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_owner_o != '0) |->
      (status_o == STATUS_OK && slot_index_o == '0 && slot_generation_o == '0))
    else $error("owner returned with slot data");

  // Nothing is in flight right after reset, so the queue cannot be full.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!busy && !done_o))
    else $error("busy or result right after reset");

endmodule

bind generational_handle_allocator gah_checker #(
  .SLOT_COUNT (SLOT_COUNT)
) u_gah_checker (.*);
